[src/xclts_pkg.sv]
// Shared types and constants for the x86 call / lea target scanner.
// No dependencies; every other file of the block refers to it by scoped names.
package xclts_pkg;

	localparam int OFS_W  = 32;
	localparam int CNT_W  = 33;
	localparam int ADDR_W = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// opcode and operand bytes
	localparam logic [7:0] OP_CALL    = 8'hE8;
	localparam logic [7:0] REX_W      = 8'h48;
	localparam logic [7:0] REX_WR     = 8'h4C;
	localparam logic [7:0] OP_LEA     = 8'h8D;
	localparam logic [7:0] MODRM_MASK = 8'hC7;
	localparam logic [7:0] MODRM_RIP  = 8'h05;
	localparam logic [7:0] INT3       = 8'hCC;

	// instruction lengths (window lengths)
	localparam logic [2:0] CALL_LEN = 3'd5;
	localparam logic [2:0] LEA_LEN  = 3'd7;

	localparam logic MODE_CALL = 1'b0;
	localparam logic MODE_LEA  = 1'b1;

	localparam logic KIND_HIT  = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_IMAGE_SIZE = 2'd0;
	localparam logic [1:0] REG_ENTRY      = 2'd1;
	localparam logic [1:0] REG_MAX_BODY   = 2'd2;
	localparam logic [1:0] REG_SCAN_MODE  = 2'd3;

	typedef struct packed {
		logic [OFS_W-1:0] image_size;
		logic [OFS_W-1:0] entry_offset;
		logic [OFS_W-1:0] max_body_bytes;
		logic             scan_mode;
	} cfg_t;

	// all results caused by one byte: an optional hit, then an optional done
	typedef struct packed {
		logic             hit;
		logic             done;
		logic [OFS_W-1:0] site;
		logic [OFS_W-1:0] target;
	} rec_t;

endpackage

[src/xclts_cfg.sv]
// APB-style register file of the scanner.
// Depends on xclts_pkg (cfg_t, register indexes).
module xclts_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xclts_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output xclts_pkg::cfg_t               cfg
);

	xclts_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				xclts_pkg::REG_IMAGE_SIZE: cfg_q.image_size     <= pwdata;
				xclts_pkg::REG_ENTRY:      cfg_q.entry_offset   <= pwdata;
				xclts_pkg::REG_MAX_BODY:   cfg_q.max_body_bytes <= pwdata;
				xclts_pkg::REG_SCAN_MODE:  cfg_q.scan_mode      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			xclts_pkg::REG_IMAGE_SIZE: prdata = cfg_q.image_size;
			xclts_pkg::REG_ENTRY:      prdata = cfg_q.entry_offset;
			xclts_pkg::REG_MAX_BODY:   prdata = cfg_q.max_body_bytes;
			xclts_pkg::REG_SCAN_MODE:  prdata = {31'd0, cfg_q.scan_mode};
			default:                   prdata = '0;
		endcase
	end

endmodule

[src/xclts_core.sv]
// Scan core: input byte register, byte window, counters, site match and
// target check. Emits a result record for each byte with a hit or a done. Depends on xclts_pkg.
module xclts_core (
	input  logic                clk,
	input  logic                arst_n,
	input  xclts_pkg::cfg_t     cfg,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	output logic                in_ready,
	input  logic                q_full,
	output logic                push,
	output xclts_pkg::rec_t     push_rec
);

	logic                          vld_s1;
	logic [7:0]                    byte_s1;
	logic [7:0]                    win_q [6];
	logic [xclts_pkg::CNT_W-1:0]   cnt_q;
	logic [xclts_pkg::OFS_W-1:0]   slen_q;
	logic                          sent_q;
	logic                          done_q;

	logic                          fire;
	logic [7:0]                    w [7];
	logic [xclts_pkg::OFS_W-1:0]   rem, cap, blen;
	logic [xclts_pkg::CNT_W-1:0]   n, r, last_cand, last;
	logic                          sent_hit, match, hit, done;
	logic [2:0]                    wl;
	logic [33:0]                   s7, site;
	logic [34:0]                   tsum;
	logic [31:0]                   disp;

	assign fire     = vld_s1 & ~q_full;
	assign in_ready = ~vld_s1 | ~q_full;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			w[i] = win_q[i];
		end
		w[6] = byte_s1;
	end

	// body length follows the registers until the INT3 run freezes it
	assign rem = (cfg.image_size > cfg.entry_offset) ?
		cfg.image_size - cfg.entry_offset : '0;
	assign cap = (cfg.max_body_bytes < rem) ? cfg.max_body_bytes : rem;

	assign sent_hit = ~sent_q && (cnt_q >= 33'd2) && (cnt_q < {1'b0, cap}) &&
		(w[4] == xclts_pkg::INT3) && (w[5] == xclts_pkg::INT3) &&
		(w[6] == xclts_pkg::INT3);

	always_comb begin
		if (sent_q) begin
			blen = slen_q;
		end else if (sent_hit) begin
			blen = xclts_pkg::OFS_W'(cnt_q - 33'd2);
		end else begin
			blen = cap;
		end
	end

	assign n  = (cnt_q == xclts_pkg::CNT_MAX) ? cnt_q : cnt_q + 33'd1;
	assign wl = (cfg.scan_mode == xclts_pkg::MODE_LEA) ? xclts_pkg::LEA_LEN :
		xclts_pkg::CALL_LEN;
	assign r  = n - 33'(wl);

	// s7 = next-instruction offset
	assign s7   = {2'b00, cfg.entry_offset} + {1'b0, n};
	assign site = s7 - 34'(wl);
	assign disp = {w[6], w[5], w[4], w[3]};
	assign tsum = {1'b0, s7} + {{3{disp[31]}}, disp};

	always_comb begin
		if (cfg.scan_mode == xclts_pkg::MODE_LEA) begin
			match = ((w[0] == xclts_pkg::REX_W) || (w[0] == xclts_pkg::REX_WR)) &&
				(w[1] == xclts_pkg::OP_LEA) &&
				((w[2] & xclts_pkg::MODRM_MASK) == xclts_pkg::MODRM_RIP);
		end else begin
			match = (w[2] == xclts_pkg::OP_CALL);
		end
	end

	assign hit = match && (n >= 33'(wl)) && (r < {1'b0, blen}) &&
		(s7 <= {2'b00, cfg.image_size}) && ~tsum[34] &&
		(tsum[33:0] < {2'b00, cfg.image_size}) &&
		((cfg.scan_mode == xclts_pkg::MODE_LEA) || (tsum[33:0] != '0));

	assign last_cand = {1'b0, blen} + 33'(wl) - 33'd1;
	assign last      = (last_cand < {1'b0, rem}) ? last_cand : {1'b0, rem};
	assign done      = (blen == '0) || (n >= last);

	assign push            = fire & ~done_q & (hit | done);
	assign push_rec.hit    = hit;
	assign push_rec.done   = done;
	assign push_rec.site   = site[xclts_pkg::OFS_W-1:0];
	assign push_rec.target = tsum[xclts_pkg::OFS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
			cnt_q  <= '0;
			slen_q <= '0;
			sent_q <= 1'b0;
			done_q <= 1'b0;
		end else if (fire && !done_q) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= w[i+1];
			end
			cnt_q <= n;
			if (sent_hit) begin
				sent_q <= 1'b1;
				slen_q <= blen;
			end
			if (done) begin
				done_q <= 1'b1;
			end
		end
	end

endmodule

[src/xclts_outq.sv]
// Four-deep result record queue and serializer onto the result stream.
// A record with a hit and a done goes out as two requests. Depends on xclts_pkg.
module xclts_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  xclts_pkg::rec_t     push_rec,
	output logic                full,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         out_data,
	output logic                out_kind,
	output logic                out_last
);

	xclts_pkg::rec_t  buf_q [4];
	logic [1:0]       wr_ptr_q, rd_ptr_q;
	logic [2:0]       cnt_q;
	logic             phase_q;
	xclts_pkg::rec_t  head;
	logic             send_hit, take, pop;

	assign head      = buf_q[rd_ptr_q];
	assign full      = (cnt_q == 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign send_hit  = head.hit & ~phase_q;

	always_comb begin
		if (send_hit) begin
			out_kind = xclts_pkg::KIND_HIT;
			out_data = {head.target, head.site};
			out_last = ~head.done;
		end else begin
			out_kind = xclts_pkg::KIND_DONE;
			out_data = '0;
			out_last = 1'b1;
		end
	end

	assign take = out_valid & out_ready;
	assign pop  = take & out_last;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
				phase_q  <= 1'b0;
			end else if (take) begin
				phase_q <= 1'b1;
			end
			cnt_q <= cnt_q + {2'b00, push} - {2'b00, pop};
		end
	end

endmodule

[src/x86_call_lea_target_scanner.sv]
// Top level of the x86 call / rip-relative lea target scanner.
// Depends on xclts_pkg, xclts_cfg, xclts_core and xclts_outq.
//
// Usage:
//  - Program image_size, entry_offset, max_body_bytes and scan_mode over the
//    APB port (byte addresses 0x0, 0x4, 0x8, 0xC) while the block is idle.
//  - Stream image bytes on s_axis, one byte per request, starting at the
//    entry offset. Each byte goes into an input register and is scanned from
//    there against the window of the six bytes before it.
//  - m_axis carries results: tuser=0 a hit (site, target), tuser=1 the one
//    done request that ends the scan; tlast marks the last result of a byte.
//  - A byte's results pass the input register and the result queue before they reach m_axis.
//  - Throughput: one byte per cycle while the result queue is not full. The
//    byte that ends the scan with a hit gives two requests on the result
//    port; bytes after done are taken and dropped.
//  - A four-deep result queue sits between scan and result port; s_axis
//    keeps taking bytes while results wait, and stalls only once the queue
//    is full under a stalled m_axis.
//  - Reset clears the registers, window, counters and queue; after reset
//    the body is empty, so the first byte gives the done request only.
module x86_call_lea_target_scanner (
	input  logic                         clk,
	input  logic                         arst_n,
	// image bytes: [7:0] data_byte
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,
	// results: [31:0] site_offset, [63:32] target_offset
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [63:0]                  m_axis_tdata,
	// results: [0] item_kind
	output logic                         m_axis_tuser,
	output logic                         m_axis_tlast,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [xclts_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	xclts_pkg::cfg_t cfg;
	xclts_pkg::rec_t rec;
	logic            push, q_full;

	xclts_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// window, counters, match and target range check
	xclts_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_ready (s_axis_tready),
		.q_full   (q_full),
		.push     (push),
		.push_rec (rec)
	);

	// result queue; splits hit+done records into two requests
	xclts_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (rec),
		.full      (q_full),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

[tb/tb_x86_call_lea_target_scanner.sv]
`timescale 1ns / 100ps
// Self-checking bench for x86_call_lea_target_scanner: streams image bytes, predicts
// call / rip-relative lea hits and the done request, and checks every result request.
// Depends on xclts_pkg and the scanner RTL under src.
module tb_x86_call_lea_target_scanner;

	localparam int STALL_LIMIT  = 5000;  // cycles without any accepted request
	localparam int PHASES       = 7;
	localparam int PHASE_BYTES  = 250;
	localparam int PRINT_LIMIT  = 100;

	// one result request as seen on m_axis
	typedef struct packed {
		logic        kind;
		logic [31:0] site;
		logic [31:0] target;
		logic        last;
	} scan_report_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [xclts_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the registers and scan state (reset values)
	logic [31:0] img_size  = '0;
	logic [31:0] entry_ofs = '0;
	logic [31:0] body_cap  = '0;
	logic        mode_sel  = xclts_pkg::MODE_CALL;
	logic [7:0]  win [0:5] = '{default: 8'h00};
	logic [63:0] rcvd      = '0;
	logic [63:0] body_limit = '0;
	logic        sentinel_seen = 1'b0;
	logic        scan_over     = 1'b0;

	logic [7:0]   image_bytes [$];     // bytes waiting for the driver
	scan_report_t pending_reports [$]; // results predicted, not yet seen
	int bytes_queued = 0;
	int bytes_taken  = 0;
	int mismatches   = 0;
	int idle_pct     = 26;
	int stall_cycles = 0;

	x86_call_lea_target_scanner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns  mismatch: %s", $realtime, msg);
	endtask

	// bytes left in the image past the entry offset; zero when entry is beyond it
	function automatic logic [63:0] image_rest();
		return (img_size > entry_ofs) ? 64'(img_size - entry_ofs) : 64'd0;
	endfunction

	// Works out the hit / done requests one accepted byte causes and queues them.
	function automatic void predict_scan_reports(input logic [7:0] b);
		logic [7:0]   w [0:6];
		logic [63:0]  k, n, wl, r, site, disp, tgt, stop_at;
		logic         match, hit, done;
		scan_report_t rep;
		if (scan_over)
			return;
		for (int i = 0; i < 6; i++)
			w[i] = win[i];
		w[6] = b;
		k = rcvd;
		n = (k < 64'(xclts_pkg::CNT_MAX)) ? k + 1 : k;

		// first int3 run inside the body closes it; only counted once
		if (!sentinel_seen && k >= 2 && k < body_limit &&
			w[4] == xclts_pkg::INT3 && w[5] == xclts_pkg::INT3 &&
			w[6] == xclts_pkg::INT3) begin
			sentinel_seen = 1'b1;
			body_limit = k - 2;
		end

		wl  = (mode_sel == xclts_pkg::MODE_LEA) ? 64'(xclts_pkg::LEA_LEN) :
			64'(xclts_pkg::CALL_LEN);
		hit = 1'b0;
		if (n >= wl) begin
			r    = n - wl;
			site = 64'(entry_ofs) + r;
			if (mode_sel == xclts_pkg::MODE_LEA)
				match = (w[0] == xclts_pkg::REX_W || w[0] == xclts_pkg::REX_WR) &&
					w[1] == xclts_pkg::OP_LEA &&
					(w[2] & xclts_pkg::MODRM_MASK) == xclts_pkg::MODRM_RIP;
			else
				match = (w[2] == xclts_pkg::OP_CALL);
			if (match && r < body_limit && site + wl <= 64'(img_size)) begin
				disp = {{32{w[6][7]}}, w[6], w[5], w[4], w[3]};
				tgt  = site + wl + disp;
				// zero call target is refused, zero lea target goes downstream
				hit  = (tgt < 64'(img_size)) &&
					(mode_sel == xclts_pkg::MODE_LEA || tgt != 0);
			end
		end

		for (int i = 0; i < 5; i++)
			win[i] = w[i + 1];
		win[5] = w[6];
		rcvd = n;

		stop_at = body_limit + wl - 1;
		if (image_rest() < stop_at)
			stop_at = image_rest();
		done = (body_limit == 0) || (n >= stop_at);

		if (hit) begin
			rep.kind   = xclts_pkg::KIND_HIT;
			rep.site   = site[31:0];
			rep.target = tgt[31:0];
			rep.last   = !done;
			pending_reports = {pending_reports, rep};
		end
		if (done) begin
			scan_over  = 1'b1;
			rep.kind   = xclts_pkg::KIND_DONE;
			rep.site   = '0;
			rep.target = '0;
			rep.last   = 1'b1;
			pending_reports = {pending_reports, rep};
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		image_bytes = {image_bytes, b};
		bytes_queued++;
	endfunction

	// Queues one call or lea instruction whose displacement lands on tgt.
	function automatic void push_site(input logic lea, input logic [7:0] pfx,
		input logic [7:0] modrm, input logic [31:0] tgt);
		logic [31:0] disp;
		disp = tgt - (entry_ofs + 32'(bytes_queued) +
			((lea == xclts_pkg::MODE_LEA) ? 32'(xclts_pkg::LEA_LEN) :
			32'(xclts_pkg::CALL_LEN)));
		if (lea == xclts_pkg::MODE_LEA) begin
			push_byte(pfx);
			push_byte(xclts_pkg::OP_LEA);
			push_byte(modrm);
		end else
			push_byte(xclts_pkg::OP_CALL);
		for (int i = 0; i < 4; i++)
			push_byte(disp[8*i +: 8]);
	endfunction

	// Mostly well-formed sites of the current mode, some of the other mode,
	// the rest random bytes. Targets cluster on the image edges and near the site.
	function automatic void push_mixed(input int count);
		int          stop, sel;
		logic        lea;
		logic [31:0] here, tgt;
		logic [7:0]  modrm;
		stop = bytes_queued + count;
		while (bytes_queued < stop) begin
			sel = $urandom_range(0, 99);
			if (sel >= 70) begin
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom));
			end else begin
				lea  = (sel < 55) ? mode_sel : !mode_sel;
				here = entry_ofs + 32'(bytes_queued);
				case ($urandom_range(0, 7))
					0: tgt = 32'd0;
					1: tgt = img_size - 1;
					2: tgt = img_size;
					3: tgt = $urandom;
					4, 5: tgt = $urandom_range(0, img_size - 1);
					default: tgt = here + 32'($urandom_range(0, 4000)) - 32'd2000;
				endcase
				// mostly mod=00 rm=101, now and then any modrm
				modrm = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
					{2'b00, 3'($urandom), 3'b101};
				push_site(lea, $urandom_range(0, 1) ? xclts_pkg::REX_W : xclts_pkg::REX_WR,
					modrm, tgt);
			end
		end
	endfunction

	// APB write: setup, access; register lands at the edge with pready high.
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= xclts_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			xclts_pkg::REG_IMAGE_SIZE: img_size  = val;
			xclts_pkg::REG_ENTRY:      entry_ofs = val;
			xclts_pkg::REG_MAX_BODY:   body_cap  = val;
			xclts_pkg::REG_SCAN_MODE:  mode_sel  = val[0];
			default: ;
		endcase
		// body length only follows the registers until a sentinel was seen
		if (!sentinel_seen)
			body_limit = (64'(body_cap) < image_rest()) ? 64'(body_cap) : image_rest();
	endtask

	// Block idle: every byte taken, every result seen, the pipeline flushed.
	task automatic wait_drained();
		while (bytes_taken != bytes_queued || pending_reports.size() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	// Request driver: holds tvalid until the byte is taken, then pulls the next one.
	always @(posedge clk) begin : byte_feed
		logic       nxt_valid;
		logic [7:0] nxt_data;
		if (arst_n) begin
			nxt_valid = s_axis_tvalid;
			nxt_data  = s_axis_tdata;
			if (s_axis_tvalid && s_axis_tready) begin
				predict_scan_reports(s_axis_tdata);
				bytes_taken++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && image_bytes.size() > 0 &&
				$urandom_range(0, 99) >= idle_pct) begin
				nxt_valid = 1'b1;
				nxt_data  = image_bytes.pop_front();
			end
			s_axis_tvalid <= nxt_valid;
			s_axis_tdata  <= nxt_data;
		end
	end

	// Result monitor: each accepted request against the oldest prediction.
	always @(posedge clk) begin : result_check
		scan_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0)
				report_mismatch($sformatf("unexpected result kind %0b site %h target %h",
					m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]));
			else begin
				want = pending_reports.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch($sformatf("kind %0b, want %0b", m_axis_tuser, want.kind));
				if (m_axis_tdata[31:0] !== want.site)
					report_mismatch($sformatf("site %h, want %h",
						m_axis_tdata[31:0], want.site));
				if (m_axis_tdata[63:32] !== want.target)
					report_mismatch($sformatf("target %h, want %h (site %h)",
						m_axis_tdata[63:32], want.target, want.site));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("tlast %0b, want %0b (site %h)",
						m_axis_tlast, want.last, want.site));
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(0, 99) >= idle_pct);
	end

	// Watchdog: a hang on either stream ends the run.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_x86_call_lea_target_scanner failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] ent, img, cap;
		int          ending;

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero call target, targets on both sides of the image end,
		// then lea with both prefixes, one aimed at offset zero.
		apb_write(xclts_pkg::REG_IMAGE_SIZE, 32'h0000_2000);
		apb_write(xclts_pkg::REG_ENTRY, 32'h0000_0100);
		apb_write(xclts_pkg::REG_MAX_BODY, 32'hFFFF_FFFF);
		apb_write(xclts_pkg::REG_SCAN_MODE, 32'(xclts_pkg::MODE_CALL));
		push_site(xclts_pkg::MODE_CALL, xclts_pkg::REX_W, xclts_pkg::MODRM_RIP, 32'd0);
		push_site(xclts_pkg::MODE_CALL, xclts_pkg::REX_W, xclts_pkg::MODRM_RIP,
			img_size - 1);
		push_site(xclts_pkg::MODE_CALL, xclts_pkg::REX_W, xclts_pkg::MODRM_RIP, img_size);
		wait_drained();
		apb_write(xclts_pkg::REG_SCAN_MODE, 32'(xclts_pkg::MODE_LEA));
		push_site(xclts_pkg::MODE_LEA, xclts_pkg::REX_W, xclts_pkg::MODRM_RIP, 32'd0);
		push_site(xclts_pkg::MODE_LEA, xclts_pkg::REX_WR, 8'h3D, img_size - 1);

		// Random phases, each with fresh registers; the body always reaches
		// well past the bytes still to come, so the scan stays open.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			idle_pct = (p == 3) ? 0 : 26;  // one long stretch at full rate
			if (p == 1) begin
				ent = 32'd0;
				img = 32'hFFFF_FFFF;
				cap = 32'hFFFF_FFFF;
			end else if (p == 4) begin
				// image top: sites and targets near the 32-bit limit
				ent = 32'hFFFF_F000;
				img = 32'hFFFF_FFFF;
				cap = $urandom_range(8192, 65536);
			end else begin
				ent = $urandom_range(0, 1) ? $urandom_range(0, 4095) :
					$urandom_range(0, 32'h7FFF_0000);
				img = ent + $urandom_range(8192, 65536);
				cap = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(8192, 65536);
			end
			apb_write(xclts_pkg::REG_ENTRY, ent);
			apb_write(xclts_pkg::REG_IMAGE_SIZE, img);
			apb_write(xclts_pkg::REG_MAX_BODY, cap);
			apb_write(xclts_pkg::REG_SCAN_MODE, $urandom_range(0, 1));
			push_mixed(PHASE_BYTES);
		end

		// Close the scan one of several ways; bytes after done are dropped.
		wait_drained();
		idle_pct = 26;
		ending = $urandom_range(0, 6);
		case (ending)
			0: begin
				// int3 run ends the body
				push_mixed(30);
				repeat (3)
					push_byte(xclts_pkg::INT3);
				push_mixed(30);
			end
			1: begin
				// cap just ahead of the position
				apb_write(xclts_pkg::REG_MAX_BODY, bytes_queued + $urandom_range(0, 24));
				push_mixed(48);
			end
			2: begin
				// image end just ahead of the position
				apb_write(xclts_pkg::REG_IMAGE_SIZE,
					entry_ofs + bytes_queued + $urandom_range(0, 24));
				push_mixed(48);
			end
			3: begin
				// image shrinks under a call whose window is still open
				apb_write(xclts_pkg::REG_SCAN_MODE, 32'(xclts_pkg::MODE_CALL));
				push_site(xclts_pkg::MODE_CALL, xclts_pkg::REX_W, xclts_pkg::MODRM_RIP,
					entry_ofs);
				push_byte(xclts_pkg::OP_CALL);
				repeat (3)
					push_byte(8'($urandom));
				wait_drained();
				apb_write(xclts_pkg::REG_IMAGE_SIZE, entry_ofs + bytes_queued - 2);
				push_mixed(8);
			end
			4: begin
				// entry beyond the image
				apb_write(xclts_pkg::REG_ENTRY, 32'hFFFF_FFFF);
				push_mixed(8);
			end
			5: begin
				apb_write(xclts_pkg::REG_MAX_BODY, 32'd0);
				push_mixed(8);
			end
			default: begin
				apb_write(xclts_pkg::REG_IMAGE_SIZE, 32'd0);
				push_mixed(8);
			end
		endcase

		wait_drained();
		repeat (14)
			@(posedge clk);
		if (mismatches == 0)
			$display("tb_x86_call_lea_target_scanner passed");
		else
			$display("tb_x86_call_lea_target_scanner failed");
		$finish;
	end

endmodule
